// ===== hw/rtl/adpcm_pkg.sv =====
package adpcm_pkg;

    localparam int STEP_ENTRIES = 89;
    localparam int INDEX_MAX    = STEP_ENTRIES - 1;
    localparam int IDX_W        = $clog2(STEP_ENTRIES);
    localparam int STEP_W       = 15;
    localparam int SAMPLE_W     = 16;
    localparam int CODE_W       = 3;
    localparam int NIB_W        = 4;
    localparam int REM_W        = 18;
    localparam int PROD_W       = 18;
    localparam int DIFF_W       = 17;
    localparam int PSUM_W       = 18;
    localparam int ADJ_W        = 5;
    localparam int IDXS_W       = 8;

    localparam logic [CODE_W-1:0]        CODE_MAX = 3'd7;
    localparam logic [1:0]               DIV_LAST = 2'd3;
    localparam logic signed [PSUM_W-1:0] PRED_MAX = 18'sd32767;
    localparam logic signed [PSUM_W-1:0] PRED_MIN = -18'sd32768;
    localparam logic [IDX_W-1:0]         IDX_TOP  = IDX_W'(INDEX_MAX);

    localparam logic [STEP_W-1:0] STEP_ROM [0:STEP_ENTRIES-1] = '{
        15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
        15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
        15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107,
        15'd118, 15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230,
        15'd253, 15'd279, 15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494,
        15'd544, 15'd598, 15'd658, 15'd724, 15'd796, 15'd876, 15'd963, 15'd1060,
        15'd1166, 15'd1282, 15'd1411, 15'd1552, 15'd1707, 15'd1878, 15'd2066,
        15'd2272, 15'd2499, 15'd2749, 15'd3024, 15'd3327, 15'd3660, 15'd4026,
        15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484, 15'd7132, 15'd7845,
        15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635, 15'd13899, 15'd15289,
        15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086, 15'd29794,
        15'd32767
    };

    typedef struct packed {
        logic                       func;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_in_block;
    } in_item_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       block_end;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_DIV,
        ST_MUL,
        ST_UPD
    } state_t;

    typedef struct packed {
        logic       load;
        logic       diff;
        logic       div;
        logic [1:0] div_cnt;
        logic       mul;
        logic       commit;
    } dp_cmd_t;

    typedef struct packed {
        logic emit;
    } dp_status_t;

    function automatic logic [STEP_W-1:0] step_lookup(input logic [IDX_W-1:0] idx);
        logic [STEP_W-1:0] s;
        if (idx > IDX_TOP)
        begin
            s = STEP_ROM[IDX_TOP];
        end
        else
        begin
            s = STEP_ROM[idx];
        end
        return s;
    endfunction

    function automatic logic signed [ADJ_W-1:0] index_adjust(input logic [CODE_W-1:0] code);
        logic signed [ADJ_W-1:0] a;
        case (code)
            3'd4:    a = 5'sd2;
            3'd5:    a = 5'sd4;
            3'd6:    a = 5'sd6;
            3'd7:    a = 5'sd8;
            default: a = -5'sd1;
        endcase
        return a;
    endfunction

endpackage

// ===== hw/rtl/adpcm_if.sv =====
interface adpcm_stream_if #(
    parameter type payload_t = logic [7:0]
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/adpcm_ctrl.sv =====
module adpcm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_func,
    output logic                  in_ready,
    input  logic                  out_ready,
    output logic                  out_valid,
    input  adpcm_pkg::dp_status_t status,
    output adpcm_pkg::dp_cmd_t    cmd
);

    adpcm_pkg::state_t state_reg;
    adpcm_pkg::state_t state_next;
    logic [1:0]        div_cnt_reg;
    logic [1:0]        div_cnt_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= adpcm_pkg::ST_IDLE;
            div_cnt_reg   <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.div_cnt  = div_cnt_reg;
        case (state_reg)
            adpcm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = in_func ? adpcm_pkg::ST_UPD : adpcm_pkg::ST_DIFF;
                end
            end
            adpcm_pkg::ST_DIFF:
            begin
                cmd.diff     = 1'b1;
                div_cnt_next = 2'd0;
                state_next   = adpcm_pkg::ST_DIV;
            end
            adpcm_pkg::ST_DIV:
            begin
                cmd.div      = 1'b1;
                div_cnt_next = div_cnt_reg + 2'd1;
                if (div_cnt_reg == adpcm_pkg::DIV_LAST)
                begin
                    state_next = adpcm_pkg::ST_MUL;
                end
            end
            adpcm_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = adpcm_pkg::ST_UPD;
            end
            adpcm_pkg::ST_UPD:
            begin
                // hold here while a byte is due and the output slot is taken
                if (!status.emit || slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = adpcm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = adpcm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit && status.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && status.emit) |-> (!out_valid_reg || out_ready))
        else $error("byte committed over an untaken byte");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && status.emit) |=> out_valid_reg)
        else $error("committed byte not presented");

    a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == adpcm_pkg::ST_MUL) |-> ($past(div_cnt_reg) == adpcm_pkg::DIV_LAST))
        else $error("quotient finished before all steps");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !in_func) |=> !in_ready ##1 !in_ready)
        else $error("new item taken while an encode is in flight");

endmodule

// ===== hw/rtl/adpcm_dp.sv =====
module adpcm_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  adpcm_pkg::in_item_t   in_item,
    input  adpcm_pkg::dp_cmd_t    cmd,
    output adpcm_pkg::dp_status_t status,
    output adpcm_pkg::out_item_t  out_item
);

    // item latched at accept
    logic                                  func_reg;
    logic signed [adpcm_pkg::SAMPLE_W-1:0] sample_reg;
    logic                                  last_reg;

    // codec state
    logic signed [adpcm_pkg::SAMPLE_W-1:0] pred_reg;
    logic signed [adpcm_pkg::SAMPLE_W-1:0] pred_next;
    logic [adpcm_pkg::IDX_W-1:0]           idx_reg;
    logic [adpcm_pkg::IDX_W-1:0]           idx_next;
    logic                                  phase_reg;
    logic                                  phase_next;
    logic [adpcm_pkg::NIB_W-1:0]           held_reg;
    logic [adpcm_pkg::NIB_W-1:0]           held_next;

    // working registers
    logic [adpcm_pkg::STEP_W-1:0]          step_reg;
    logic                                  sign_reg;
    logic [adpcm_pkg::REM_W-1:0]           rem_reg;
    logic [adpcm_pkg::CODE_W-1:0]          code_reg;
    logic                                  sat_reg;
    logic [adpcm_pkg::PROD_W-1:0]          prod_reg;
    logic [7:0]                            byte_reg;
    logic [7:0]                            byte_next;
    logic                                  end_reg;
    logic                                  end_next;

    logic signed [adpcm_pkg::SAMPLE_W:0]   d_w;
    logic [adpcm_pkg::SAMPLE_W:0]          d_abs_w;
    logic [adpcm_pkg::REM_W-1:0]           trial_w;
    logic                                  ge_w;
    logic [adpcm_pkg::CODE_W-1:0]          code_fin_w;
    logic [adpcm_pkg::DIFF_W-1:0]          diff_w;
    logic signed [adpcm_pkg::PSUM_W-1:0]   psum_w;
    logic signed [adpcm_pkg::ADJ_W-1:0]    adj_w;
    logic signed [adpcm_pkg::IDXS_W-1:0]   isum_w;
    logic [adpcm_pkg::NIB_W-1:0]           nib_w;

    assign d_w     = {sample_reg[adpcm_pkg::SAMPLE_W-1], sample_reg}
                   - {pred_reg[adpcm_pkg::SAMPLE_W-1], pred_reg};
    assign d_abs_w = d_w[adpcm_pkg::SAMPLE_W] ? $unsigned(-d_w) : $unsigned(d_w);

    // first step tests quotient >= 8 (saturate), then restoring bits 2..0
    always_comb
    begin
        case (cmd.div_cnt)
            2'd0:    trial_w = {step_reg, 3'b000};
            2'd1:    trial_w = {1'b0, step_reg, 2'b00};
            2'd2:    trial_w = {2'b00, step_reg, 1'b0};
            default: trial_w = {3'b000, step_reg};
        endcase
    end

    assign ge_w       = rem_reg >= trial_w;
    assign code_fin_w = sat_reg ? adpcm_pkg::CODE_MAX : code_reg;

    assign diff_w = adpcm_pkg::DIFF_W'(prod_reg[adpcm_pkg::PROD_W-1:2])
                  + adpcm_pkg::DIFF_W'(step_reg[adpcm_pkg::STEP_W-1:3]);
    assign psum_w = sign_reg
                  ? adpcm_pkg::PSUM_W'(pred_reg) - $signed({1'b0, diff_w})
                  : adpcm_pkg::PSUM_W'(pred_reg) + $signed({1'b0, diff_w});

    assign adj_w  = adpcm_pkg::index_adjust(code_reg);
    assign isum_w = $signed({1'b0, idx_reg})
                  + {{(adpcm_pkg::IDXS_W - adpcm_pkg::ADJ_W){adj_w[adpcm_pkg::ADJ_W-1]}},
                     adj_w};
    assign nib_w  = {sign_reg, code_reg};

    always_comb
    begin
        pred_next  = pred_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        held_next  = held_reg;
        byte_next  = byte_reg;
        end_next   = end_reg;
        if (func_reg)
        begin
            pred_next = '0;
            idx_next  = '0;
            byte_next = {held_reg, 4'h0};
            end_next  = 1'b1;
            if (last_reg && phase_reg)
            begin
                phase_next = 1'b0;
                held_next  = '0;
            end
        end
        else
        begin
            if (psum_w > adpcm_pkg::PRED_MAX)
            begin
                pred_next = adpcm_pkg::PRED_MAX[adpcm_pkg::SAMPLE_W-1:0];
            end
            else if (psum_w < adpcm_pkg::PRED_MIN)
            begin
                pred_next = adpcm_pkg::PRED_MIN[adpcm_pkg::SAMPLE_W-1:0];
            end
            else
            begin
                pred_next = psum_w[adpcm_pkg::SAMPLE_W-1:0];
            end

            if (isum_w < 0)
            begin
                idx_next = '0;
            end
            else if (isum_w > $signed({1'b0, adpcm_pkg::IDX_TOP}))
            begin
                idx_next = adpcm_pkg::IDX_TOP;
            end
            else
            begin
                idx_next = isum_w[adpcm_pkg::IDX_W-1:0];
            end

            if (phase_reg)
            begin
                byte_next  = {held_reg, nib_w};
                end_next   = last_reg;
                phase_next = 1'b0;
                held_next  = '0;
            end
            else if (last_reg)
            begin
                byte_next = {nib_w, 4'h0};
                end_next  = 1'b1;
            end
            else
            begin
                held_next  = nib_w;
                phase_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg  <= '0;
            idx_reg   <= '0;
            phase_reg <= 1'b0;
            held_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            pred_reg  <= pred_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= in_item.func;
            sample_reg <= in_item.sample;
            last_reg   <= in_item.last_in_block;
        end
        if (cmd.diff)
        begin
            step_reg <= adpcm_pkg::step_lookup(idx_reg);
            sign_reg <= d_w[adpcm_pkg::SAMPLE_W];
            rem_reg  <= {d_abs_w[adpcm_pkg::SAMPLE_W-1:0], 2'b00};
            code_reg <= '0;
            sat_reg  <= 1'b0;
        end
        if (cmd.div)
        begin
            if (cmd.div_cnt == 2'd0)
            begin
                sat_reg <= ge_w;
            end
            else if (ge_w)
            begin
                rem_reg <= rem_reg - trial_w;
                code_reg[adpcm_pkg::DIV_LAST - cmd.div_cnt] <= 1'b1;
            end
        end
        if (cmd.mul)
        begin
            prod_reg <= adpcm_pkg::PROD_W'(step_reg) * adpcm_pkg::PROD_W'(code_fin_w);
            code_reg <= code_fin_w;
        end
        if (cmd.commit && status.emit)
        begin
            byte_reg <= byte_next;
            end_reg  <= end_next;
        end
    end

    assign status.emit          = func_reg ? (last_reg && phase_reg) : (phase_reg || last_reg);
    assign out_item.packed_byte = byte_reg;
    assign out_item.block_end   = end_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= adpcm_pkg::IDX_TOP)
        else $error("step index left the table");

endmodule

// ===== hw/rtl/adpcm_4bit_encoder.sv =====
// 4-bit ADPCM encoder.
// samp_ch (sink) takes one item per handshake: func, sample, last_in_block.
// byte_ch (source) gives packed_byte and block_end, two codes per byte,
// earlier code in the high nibble (a lone last code gets a zero low nibble).
// An encode item passes from acceptance to the next acceptance through:
// taking it, the difference and step lookup, the quotient (the saturation
// test, then one compare-subtract per code bit), the step times code
// product, and the update of the predictor, step index and packing. A byte
// produced by an item is registered at the output when the update commits.
// A clear item (func = 1) goes from acceptance straight to the update.
// The output register holds a finished byte while the receiver stalls; the
// next item is still taken and processed, and it waits only in its update
// state if it produces a byte while the previous one is still untaken.
// Reset clears predictor, step index, packing phase and the output valid.
module adpcm_4bit_encoder (
    input  logic           clk,
    input  logic           rst_n,
    adpcm_stream_if.sink   samp_ch,
    adpcm_stream_if.source byte_ch
);

    adpcm_pkg::dp_cmd_t    cmd;
    adpcm_pkg::dp_status_t status;
    adpcm_pkg::in_item_t   in_item;
    adpcm_pkg::out_item_t  out_item;
    logic                  in_ready;
    logic                  out_valid;

    assign in_item = samp_ch.data;

    adpcm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samp_ch.valid),
        .in_func   (in_item.func),
        .in_ready  (in_ready),
        .out_ready (byte_ch.ready),
        .out_valid (out_valid),
        .status    (status),
        .cmd       (cmd)
    );

    adpcm_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .cmd      (cmd),
        .status   (status),
        .out_item (out_item)
    );

    assign samp_ch.ready = in_ready;
    assign byte_ch.valid = out_valid;
    assign byte_ch.data  = out_item;

endmodule
